FILE: rtl/core/srw_pkg.sv
// shared types, constants and codes for the sack receive window
`default_nettype none

package srw_pkg;

    localparam int SEQ_W   = 24;
    localparam int LEN_W   = 11;
    localparam int TOTAL_W = 32;

    // widest slot index over the supported window sizes
    localparam int SLOT_IDX_MAX_W = 8;

    localparam int WINDOW_SLOTS_DEF  = 32;
    localparam int SEGMENT_BYTES_DEF = 1024;

    typedef enum logic [1:0] {
        ST_IN_ORDER     = 2'd0,
        ST_OUT_OF_ORDER = 2'd1,
        ST_CORRUPT      = 2'd2,
        ST_BEYOND       = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SETTLE
    } state_t;

    typedef struct packed {
        logic                      wr_en;
        logic [SLOT_IDX_MAX_W-1:0] wr_idx;
        logic                      wr_fin;
        logic [LEN_W-1:0]          wr_len;
        logic                      rd_en;
        logic [SLOT_IDX_MAX_W-1:0] rd_idx;
        logic                      clear;
    } slot_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/srw_if.sv
// segment header and acknowledgement channel interfaces
`default_nettype none

interface srw_seg_if;
    logic                           valid;
    logic                           ready;
    logic [srw_pkg::SEQ_W-1:0]      seq_number;
    logic                           is_fin;
    logic                           checksum_ok;
    logic [srw_pkg::LEN_W-1:0]      payload_length;

    modport source (
        output valid, seq_number, is_fin, checksum_ok, payload_length,
        input  ready
    );
    modport sink (
        input  valid, seq_number, is_fin, checksum_ok, payload_length,
        output ready
    );
endinterface

interface srw_ack_if;
    logic                           valid;
    logic                           ready;
    logic [srw_pkg::SEQ_W-1:0]      ack_number;
    logic [srw_pkg::SEQ_W-1:0]      sack_number;
    logic                           fin_ack;
    logic [1:0]                     status;
    logic                           flushed;
    logic [srw_pkg::TOTAL_W-1:0]    delivered_bytes;
    logic                           transfer_done;

    modport source (
        output valid, ack_number, sack_number, fin_ack, status, flushed,
               delivered_bytes, transfer_done,
        input  ready
    );
    modport sink (
        input  valid, ack_number, sack_number, fin_ack, status, flushed,
               delivered_bytes, transfer_done,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/core/srw_slots.sv
// window slot store: filled and fin marks in flops, lengths in a memory
`default_nettype none

module srw_slots #(
    parameter int WINDOW_SLOTS = srw_pkg::WINDOW_SLOTS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire srw_pkg::slot_ctrl_t        ctrl,
    output logic [WINDOW_SLOTS-1:0]         filled,
    output logic [WINDOW_SLOTS-1:0]         fin,
    output logic [srw_pkg::LEN_W-1:0]       rd_data
);

    localparam int IDX_W = $clog2(WINDOW_SLOTS);

    logic [WINDOW_SLOTS-1:0]     filled_reg;
    logic [WINDOW_SLOTS-1:0]     filled_next;
    logic [WINDOW_SLOTS-1:0]     fin_reg;
    logic [WINDOW_SLOTS-1:0]     fin_next;
    logic [srw_pkg::LEN_W-1:0]   len_mem [WINDOW_SLOTS];
    logic [srw_pkg::LEN_W-1:0]   rd_data_reg;
    logic [IDX_W-1:0]            wr_idx;
    logic [IDX_W-1:0]            rd_idx;

    assign wr_idx = ctrl.wr_idx[IDX_W-1:0];
    assign rd_idx = ctrl.rd_idx[IDX_W-1:0];

    always_comb
    begin
        filled_next = filled_reg;
        fin_next    = fin_reg;
        if (ctrl.clear)
        begin
            filled_next = '0;
            fin_next    = '0;
        end
        else if (ctrl.wr_en)
        begin
            filled_next[wr_idx] = 1'b1;
            fin_next[wr_idx]    = ctrl.wr_fin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg <= '0;
            fin_reg    <= '0;
        end
        else
        begin
            filled_reg <= filled_next;
            fin_reg    <= fin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            len_mem[wr_idx] <= ctrl.wr_len;
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= len_mem[rd_idx];
        end
    end

    assign filled  = filled_reg;
    assign fin     = fin_reg;
    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: rtl/core/sack_receive_window.sv
// receiver window of a selective-ack transfer: one ack word per segment word
//
//   channel  modport  dir  words
//   seg      sink     in   segment header: seq, fin, checksum flag, length
//   reply    source   out  ack word: ack, sack, fin ack, status, flush, total
//
// a dropped, beyond, below-window or out-of-order segment is answered from the
// accept edge; the next one is taken the following cycle if reply is ready.
// an in-order segment walks the slots from the window start, one slot a cycle
// through the length memory read port and the saturating adder.
// reset clears all control and the slot marks at once; no clearing pass.
// a stalled reply holds its word; no new segment is taken until it can load.
`default_nettype none

module sack_receive_window #(
    parameter int WINDOW_SLOTS  = srw_pkg::WINDOW_SLOTS_DEF,
    parameter int SEGMENT_BYTES = srw_pkg::SEGMENT_BYTES_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    srw_seg_if.sink     seg,
    srw_ack_if.source   reply
);

    localparam int SEQ_W   = srw_pkg::SEQ_W;
    localparam int LEN_W   = srw_pkg::LEN_W;
    localparam int TOTAL_W = srw_pkg::TOTAL_W;
    localparam int IDX_W   = $clog2(WINDOW_SLOTS);
    localparam int CNT_W   = $clog2(WINDOW_SLOTS + 1);
    localparam int IDX_PAD = srw_pkg::SLOT_IDX_MAX_W - IDX_W;

    localparam logic [SEQ_W-1:0] SEQ_ONE    = SEQ_W'(1);
    localparam logic [SEQ_W-1:0] SEQ_SLOTS  = SEQ_W'(WINDOW_SLOTS);
    localparam logic [CNT_W-1:0] CNT_SLOTS  = CNT_W'(WINDOW_SLOTS);
    localparam logic [TOTAL_W:0] TOTAL_MAX  = {1'b0, {TOTAL_W{1'b1}}};

    srw_pkg::state_t state_reg;
    srw_pkg::state_t state_next;

    logic [SEQ_W-1:0]    next_expected_reg;
    logic [SEQ_W-1:0]    next_expected_next;
    logic [SEQ_W-1:0]    window_start_reg;
    logic [SEQ_W-1:0]    window_start_next;
    logic [TOTAL_W-1:0]  total_reg;
    logic [TOTAL_W-1:0]  total_next;
    logic                finished_reg;
    logic                finished_next;

    logic [CNT_W-1:0]    idx_reg;
    logic [CNT_W-1:0]    idx_next;
    logic [TOTAL_W-1:0]  sum_reg;
    logic [TOTAL_W-1:0]  sum_next;
    logic                fin_seen_reg;
    logic                fin_seen_next;
    logic                rd_pend_reg;
    logic                rd_pend_next;
    logic [SEQ_W-1:0]    seq_hold_reg;
    logic [SEQ_W-1:0]    seq_hold_next;
    logic                fin_hold_reg;
    logic                fin_hold_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [SEQ_W-1:0]    out_ack_reg;
    logic [SEQ_W-1:0]    out_ack_next;
    logic [SEQ_W-1:0]    out_sack_reg;
    logic [SEQ_W-1:0]    out_sack_next;
    logic                out_fin_ack_reg;
    logic                out_fin_ack_next;
    srw_pkg::status_t    out_status_reg;
    srw_pkg::status_t    out_status_next;
    logic                out_flushed_reg;
    logic                out_flushed_next;
    logic [TOTAL_W-1:0]  out_total_reg;
    logic [TOTAL_W-1:0]  out_total_next;
    logic                out_done_reg;
    logic                out_done_next;
    logic                out_load;

    srw_pkg::slot_ctrl_t      slot_ctrl;
    logic [WINDOW_SLOTS-1:0]  slot_filled;
    logic [WINDOW_SLOTS-1:0]  slot_fin;
    logic [LEN_W-1:0]         slot_rd_data;

    logic                accept;
    logic [LEN_W-1:0]    len_sat;
    logic [SEQ_W-1:0]    offset;
    logic                in_window;
    logic                below_window;
    logic                in_order;
    logic [SEQ_W-1:0]    ack_base;
    logic                cur_filled;
    logic [TOTAL_W:0]    sum_add;
    logic [TOTAL_W-1:0]  sum_sat;
    logic [SEQ_W-1:0]    settle_next_expected;
    logic                settle_flush;
    logic [SEQ_W-1:0]    ne_offset;

    srw_slots #(
        .WINDOW_SLOTS (WINDOW_SLOTS)
    ) u_slots (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (slot_ctrl),
        .filled  (slot_filled),
        .fin     (slot_fin),
        .rd_data (slot_rd_data)
    );

    assign seg.ready = (state_reg == srw_pkg::S_IDLE) && (!out_valid_reg || reply.ready);
    assign accept    = seg.valid && seg.ready;

    assign len_sat = (32'(seg.payload_length) > 32'(SEGMENT_BYTES))
                     ? LEN_W'(SEGMENT_BYTES) : seg.payload_length;
    assign offset       = seg.seq_number - window_start_reg;
    assign in_window    = offset < SEQ_SLOTS;
    assign below_window = offset[SEQ_W-1];
    assign in_order     = in_window && (seg.seq_number == next_expected_reg);
    assign ack_base     = next_expected_reg - SEQ_ONE;

    // slot under the scan pointer; the end of the window reads as a gap
    assign cur_filled = (idx_reg != CNT_SLOTS) && slot_filled[idx_reg[IDX_W-1:0]];

    // saturating adder for the flushed byte sum
    assign sum_add = {1'b0, sum_reg} + (TOTAL_W + 1)'(rd_pend_reg ? slot_rd_data : '0);
    assign sum_sat = (sum_add > TOTAL_MAX) ? {TOTAL_W{1'b1}} : sum_add[TOTAL_W-1:0];

    assign settle_next_expected = window_start_reg + SEQ_W'(idx_reg);
    assign settle_flush         = fin_seen_reg || (idx_reg == CNT_SLOTS);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            srw_pkg::S_IDLE:
            begin
                if (accept && !finished_reg && seg.checksum_ok && in_order)
                begin
                    state_next = srw_pkg::S_SCAN;
                end
            end
            srw_pkg::S_SCAN:
            begin
                if (!cur_filled)
                begin
                    state_next = srw_pkg::S_SETTLE;
                end
            end
            srw_pkg::S_SETTLE:
            begin
                state_next = srw_pkg::S_IDLE;
            end
            default:
            begin
                state_next = srw_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        next_expected_next = next_expected_reg;
        window_start_next  = window_start_reg;
        total_next         = total_reg;
        finished_next      = finished_reg;
        idx_next           = idx_reg;
        sum_next           = sum_reg;
        fin_seen_next      = fin_seen_reg;
        rd_pend_next       = 1'b0;
        seq_hold_next      = seq_hold_reg;
        fin_hold_next      = fin_hold_reg;

        out_load         = 1'b0;
        out_ack_next     = out_ack_reg;
        out_sack_next    = out_sack_reg;
        out_fin_ack_next = out_fin_ack_reg;
        out_status_next  = out_status_reg;
        out_flushed_next = out_flushed_reg;
        out_total_next   = out_total_reg;
        out_done_next    = out_done_reg;

        slot_ctrl        = '0;
        slot_ctrl.wr_idx = {{IDX_PAD{1'b0}}, offset[IDX_W-1:0]};
        slot_ctrl.wr_fin = seg.is_fin;
        slot_ctrl.wr_len = len_sat;
        slot_ctrl.rd_idx = {{IDX_PAD{1'b0}}, idx_reg[IDX_W-1:0]};

        unique case (state_reg)
            srw_pkg::S_IDLE:
            begin
                idx_next      = '0;
                sum_next      = total_reg;
                fin_seen_next = 1'b0;
                seq_hold_next = seg.seq_number;
                fin_hold_next = seg.is_fin;
                if (accept)
                begin
                    out_flushed_next = 1'b0;
                    out_total_next   = total_reg;
                    out_done_next    = finished_reg;
                    out_ack_next     = ack_base;
                    out_fin_ack_next = 1'b0;
                    out_load         = 1'b1;
                    if (finished_reg)
                    begin
                        out_ack_next     = '0;
                        out_sack_next    = '0;
                        out_fin_ack_next = 1'b1;
                        out_status_next  = srw_pkg::ST_IN_ORDER;
                    end
                    else if (!seg.checksum_ok)
                    begin
                        out_sack_next   = ack_base;
                        out_status_next = srw_pkg::ST_CORRUPT;
                    end
                    else if (!in_window && !below_window)
                    begin
                        out_sack_next   = ack_base;
                        out_status_next = srw_pkg::ST_BEYOND;
                    end
                    else
                    begin
                        // below the window, in order, or stored out of order
                        out_sack_next    = seg.seq_number;
                        out_status_next  = srw_pkg::ST_OUT_OF_ORDER;
                        out_fin_ack_next = seg.is_fin;
                        if (seg.is_fin)
                        begin
                            out_ack_next  = '0;
                            out_sack_next = '0;
                        end
                        slot_ctrl.wr_en = in_window;
                        // in order: the reply comes from the scan
                        out_load = !in_order;
                    end
                end
            end
            srw_pkg::S_SCAN:
            begin
                sum_next = sum_sat;
                if (cur_filled)
                begin
                    slot_ctrl.rd_en = 1'b1;
                    rd_pend_next    = 1'b1;
                    fin_seen_next   = fin_seen_reg | slot_fin[idx_reg[IDX_W-1:0]];
                    idx_next        = idx_reg + CNT_W'(1);
                end
            end
            srw_pkg::S_SETTLE:
            begin
                next_expected_next = settle_next_expected;
                if (settle_flush)
                begin
                    window_start_next = window_start_reg + SEQ_SLOTS;
                    total_next        = sum_reg;
                    slot_ctrl.clear   = 1'b1;
                end
                if (fin_seen_reg)
                begin
                    finished_next = 1'b1;
                end
                out_load         = 1'b1;
                out_ack_next     = fin_hold_reg ? '0 : (settle_next_expected - SEQ_ONE);
                out_sack_next    = fin_hold_reg ? '0 : seq_hold_reg;
                out_fin_ack_next = fin_hold_reg;
                out_status_next  = srw_pkg::ST_IN_ORDER;
                out_flushed_next = settle_flush;
                out_total_next   = settle_flush ? sum_reg : total_reg;
                out_done_next    = fin_seen_reg;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (reply.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= srw_pkg::S_IDLE;
            next_expected_reg <= SEQ_ONE;
            window_start_reg  <= SEQ_ONE;
            total_reg         <= '0;
            finished_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            next_expected_reg <= next_expected_next;
            window_start_reg  <= window_start_next;
            total_reg         <= total_next;
            finished_reg      <= finished_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        sum_reg         <= sum_next;
        fin_seen_reg    <= fin_seen_next;
        rd_pend_reg     <= rd_pend_next;
        seq_hold_reg    <= seq_hold_next;
        fin_hold_reg    <= fin_hold_next;
        out_ack_reg     <= out_ack_next;
        out_sack_reg    <= out_sack_next;
        out_fin_ack_reg <= out_fin_ack_next;
        out_status_reg  <= out_status_next;
        out_flushed_reg <= out_flushed_next;
        out_total_reg   <= out_total_next;
        out_done_reg    <= out_done_next;
    end

    assign reply.valid           = out_valid_reg;
    assign reply.ack_number      = out_ack_reg;
    assign reply.sack_number     = out_sack_reg;
    assign reply.fin_ack         = out_fin_ack_reg;
    assign reply.status          = out_status_reg;
    assign reply.flushed         = out_flushed_reg;
    assign reply.delivered_bytes = out_total_reg;
    assign reply.transfer_done   = out_done_reg;

    assign ne_offset = next_expected_reg - window_start_reg;

`ifndef SYNTH
    // a waiting reply word is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || reply.ready))
        else $error("reply word overwritten while stalled");

    // the next expected sequence stays inside the window until the end
    a_expected_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        !finished_reg |-> (ne_offset < SEQ_SLOTS))
        else $error("next expected sequence left the window");

    // end of transfer is sticky
    a_finished_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |=> finished_reg)
        else $error("finished mark cleared");

    // delivered byte total never falls
    a_total_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (total_reg >= $past(total_reg)))
        else $error("delivered total decreased");

    // scan pointer never runs past the window
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == srw_pkg::S_SCAN) |-> (idx_reg <= CNT_SLOTS))
        else $error("scan pointer beyond window");
`endif

endmodule

`default_nettype wire
